// ===== hw/rtl/ppd_pkg.sv =====
// shared types and constants of the point to polygon distance core
package ppd_pkg;

    localparam int CFG_INDEX_W = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_QUERY_X = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_QUERY_Y = 8'd1;

    // multiply schedule, one op per cycle, issued in this order
    localparam logic [3:0] OP_WXEY = 4'd0;
    localparam logic [3:0] OP_WYEX = 4'd1;
    localparam logic [3:0] OP_LHS  = 4'd2;
    localparam logic [3:0] OP_RHS  = 4'd3;
    localparam logic [3:0] OP_EXX  = 4'd4;
    localparam logic [3:0] OP_EYY  = 4'd5;
    localparam logic [3:0] OP_WXE  = 4'd6;
    localparam logic [3:0] OP_WYE  = 4'd7;
    localparam logic [3:0] OP_WXX  = 4'd8;
    localparam logic [3:0] OP_WYY  = 4'd9;
    localparam logic [3:0] OP_UXX  = 4'd10;
    localparam logic [3:0] OP_UYY  = 4'd11;
    localparam logic [3:0] OP_CLL  = 4'd12;
    localparam logic [3:0] OP_CHL  = 4'd13;
    localparam logic [3:0] OP_CHH  = 4'd14;
    localparam logic [3:0] OP_NOP  = 4'd15;

    typedef struct packed {
        logic       accept;
        logic       load_edge;
        logic       edge_close;
        logic [3:0] mul_op;
        logic       div_init;
        logic       div_step;
        logic       commit;
        logic       finish;
        logic       sqrt_init;
        logic       sqrt_step;
        logic       out_load;
    } ppd_cmd_t;

    typedef struct packed {
        logic loop_started;
        logic end_loop;
        logic end_region;
        logic need_div;
    } ppd_status_t;

endpackage

// ===== hw/rtl/ppd_ifs.sv =====
// request channels of the point to polygon distance core
interface ppd_vtx_if #(parameter int COORD_BITS = 24);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] vertex_x;
    logic signed [COORD_BITS-1:0] vertex_y;
    logic                         last_of_loop;
    logic                         last_of_region;

    modport source (output valid, vertex_x, vertex_y, last_of_loop, last_of_region,
                    input ready);
    modport sink (input valid, vertex_x, vertex_y, last_of_loop, last_of_region,
                  output ready);
endinterface

interface ppd_res_if #(parameter int COORD_BITS = 24);
    logic                  valid;
    logic                  ready;
    logic                  inside_res;
    logic [COORD_BITS:0]   distance;

    modport source (output valid, inside_res, distance, input ready);
    modport sink (input valid, inside_res, distance, output ready);
endinterface

interface ppd_cfg_if #(parameter int COORD_BITS = 24);
    logic                               valid;
    logic                               ready;
    logic [ppd_pkg::CFG_INDEX_W-1:0]    index;
    logic signed [COORD_BITS-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/ppd_ctrl.sv =====
// sequencer for edge evaluation, division, square root and result handoff
module ppd_ctrl #(
    parameter int COORD_BITS = 24
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  ppd_pkg::ppd_status_t status,
    output ppd_pkg::ppd_cmd_t    cmd
);

    localparam int DIV_STEPS  = 2 * COORD_BITS + 1;
    localparam int SQRT_STEPS = COORD_BITS + 1;
    localparam int CNT_W      = $clog2(2 * COORD_BITS + 2);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_NEXT   = 3'd1;
    localparam logic [2:0] S_MUL    = 3'd2;
    localparam logic [2:0] S_CHK    = 3'd3;
    localparam logic [2:0] S_DIV    = 3'd4;
    localparam logic [2:0] S_COMMIT = 3'd5;
    localparam logic [2:0] S_SQRT   = 3'd6;
    localparam logic [2:0] S_OUT    = 3'd7;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             started_reg, started_next;
    logic             closed_reg, closed_next;
    logic             out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        started_next = started_reg;
        closed_next  = closed_reg;
        cmd          = '0;
        cmd.mul_op   = ppd_pkg::OP_NOP;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept   = 1'b1;
                    started_next = status.loop_started;
                    closed_next  = 1'b0;
                    state_next   = S_NEXT;
                end
            end
            S_NEXT:
            begin
                if (started_reg)
                begin
                    cmd.load_edge = 1'b1;
                    started_next  = 1'b0;
                    cnt_next      = '0;
                    state_next    = S_MUL;
                end
                else if ((status.end_loop || status.end_region) && !closed_reg)
                begin
                    cmd.load_edge  = 1'b1;
                    cmd.edge_close = 1'b1;
                    closed_next    = 1'b1;
                    cnt_next       = '0;
                    state_next     = S_MUL;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    if (status.end_region)
                    begin
                        cmd.sqrt_init = 1'b1;
                        cnt_next      = '0;
                        state_next    = S_SQRT;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_MUL:
            begin
                cmd.mul_op = cnt_reg[3:0];
                cnt_next   = cnt_reg + CNT_W'(1);
                if (cnt_reg[3:0] == ppd_pkg::OP_NOP)
                begin
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (status.need_div)
                begin
                    cmd.div_init = 1'b1;
                    cnt_next     = '0;
                    state_next   = S_DIV;
                end
                else
                begin
                    state_next = S_COMMIT;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = S_NEXT;
            end
            S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                cnt_next      = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(SQRT_STEPS - 1))
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            started_reg   <= 1'b0;
            closed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            started_reg   <= started_next;
            closed_reg    <= closed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== hw/rtl/ppd_datapath.sv =====
// vertex state, shared multiplier, divider, square root and result registers
module ppd_datapath #(
    parameter int COORD_BITS = 24
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    input  logic [ppd_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic signed [COORD_BITS-1:0]         cfg_data,
    input  logic signed [COORD_BITS-1:0]         in_x,
    input  logic signed [COORD_BITS-1:0]         in_y,
    input  logic                                 in_last_loop,
    input  logic                                 in_last_region,
    input  ppd_pkg::ppd_cmd_t                    cmd,
    output ppd_pkg::ppd_status_t                 status,
    output logic                                 inside_res,
    output logic [COORD_BITS:0]                  distance
);

    localparam int N  = COORD_BITS;
    localparam int DW = N + 1;
    localparam int MW = N + 2;
    localparam int PW = 2 * N + 4;
    localparam int SW = 2 * N + 2;
    localparam int TW = 2 * N + 3;
    localparam int QW = 2 * N + 1;
    localparam int RW = N + 2;

    logic signed [N-1:0] qx_reg, qy_reg;
    logic signed [N-1:0] cur_x_reg, cur_y_reg, first_x_reg, first_y_reg;
    logic signed [N-1:0] prev_x_reg, prev_y_reg;
    logic                end_loop_reg, end_region_reg;
    logic                loop_started_reg, loop_par_reg, region_par_reg;
    logic [SW-1:0]       best_reg;

    logic signed [N-1:0] ax_reg, ay_reg, bx_reg, by_reg, px_reg, py_reg;

    logic signed [PW-1:0] prod_reg;
    logic [3:0]           op_reg;
    logic signed [TW-1:0] cr_reg, dot_reg;
    logic signed [PW-1:0] lhs_reg, rhs_reg;
    logic [SW-1:0]        len_reg, ww_reg, uu_reg;
    logic [2*SW-1:0]      sq_reg;

    logic [SW-1:0] dr_reg;
    logic [QW-1:0] dl_reg, q_reg;

    logic [SW-1:0] ss_reg;
    logic [RW-1:0] rem_reg;
    logic [N:0]    root_reg;

    logic          inside_reg;
    logic [N:0]    dist_reg;

    logic signed [DW-1:0] ex, ey, wx, wy, ux, uy, dyc, axb;
    logic [TW-1:0]        cneg;
    logic [SW-1:0]        cmag;
    logic signed [MW-1:0] cl, ch, op_a, op_b;
    logic                 dot_nonpos, need_div, crosses;
    logic [SW-1:0]        d2;
    logic [TW-1:0]        div_r2, div_diff;
    logic                 div_ge;
    logic [RW+1:0]        sq_r2, sq_trial, sq_diff;
    logic                 sq_ge;

    assign ex  = DW'(bx_reg) - DW'(ax_reg);
    assign ey  = DW'(by_reg) - DW'(ay_reg);
    assign wx  = DW'(px_reg) - DW'(ax_reg);
    assign wy  = DW'(py_reg) - DW'(ay_reg);
    assign ux  = DW'(px_reg) - DW'(bx_reg);
    assign uy  = DW'(py_reg) - DW'(by_reg);
    assign dyc = DW'(ay_reg) - DW'(by_reg);
    assign axb = DW'(ax_reg) - DW'(bx_reg);

    assign cneg = -cr_reg;
    assign cmag = cr_reg[TW-1] ? cneg[SW-1:0] : cr_reg[SW-1:0];
    assign cl   = $signed({1'b0, cmag[N:0]});
    assign ch   = $signed({1'b0, cmag[SW-1:N+1]});

    always_comb
    begin
        op_a = '0;
        op_b = '0;
        case (cmd.mul_op)
            ppd_pkg::OP_WXEY: begin op_a = MW'(wx);  op_b = MW'(ey);  end
            ppd_pkg::OP_WYEX: begin op_a = MW'(wy);  op_b = MW'(ex);  end
            ppd_pkg::OP_LHS:  begin op_a = MW'(ux);  op_b = MW'(dyc); end
            ppd_pkg::OP_RHS:  begin op_a = MW'(axb); op_b = MW'(uy);  end
            ppd_pkg::OP_EXX:  begin op_a = MW'(ex);  op_b = MW'(ex);  end
            ppd_pkg::OP_EYY:  begin op_a = MW'(ey);  op_b = MW'(ey);  end
            ppd_pkg::OP_WXE:  begin op_a = MW'(wx);  op_b = MW'(ex);  end
            ppd_pkg::OP_WYE:  begin op_a = MW'(wy);  op_b = MW'(ey);  end
            ppd_pkg::OP_WXX:  begin op_a = MW'(wx);  op_b = MW'(wx);  end
            ppd_pkg::OP_WYY:  begin op_a = MW'(wy);  op_b = MW'(wy);  end
            ppd_pkg::OP_UXX:  begin op_a = MW'(ux);  op_b = MW'(ux);  end
            ppd_pkg::OP_UYY:  begin op_a = MW'(uy);  op_b = MW'(uy);  end
            ppd_pkg::OP_CLL:  begin op_a = cl;       op_b = cl;       end
            ppd_pkg::OP_CHL:  begin op_a = ch;       op_b = cl;       end
            ppd_pkg::OP_CHH:  begin op_a = ch;       op_b = ch;       end
            default:          begin op_a = '0;       op_b = '0;       end
        endcase
    end

    // edge classification once all products are in
    assign dot_nonpos = dot_reg[TW-1] || (dot_reg == '0);
    assign need_div   = (len_reg != '0) && !dot_nonpos
                        && (dot_reg < $signed({1'b0, len_reg}));
    assign crosses    = ((by_reg > py_reg) != (ay_reg > py_reg))
                        && ((!dyc[DW-1] && dyc != '0) ? (lhs_reg < rhs_reg)
                                                      : (lhs_reg > rhs_reg));
    assign d2 = need_div ? {1'b0, q_reg}
              : ((len_reg == '0 || dot_nonpos) ? ww_reg : uu_reg);

    assign div_r2   = {dr_reg, dl_reg[QW-1]};
    assign div_ge   = div_r2 >= {1'b0, len_reg};
    assign div_diff = div_r2 - {1'b0, len_reg};

    assign sq_r2    = {rem_reg, ss_reg[SW-1:SW-2]};
    assign sq_trial = {1'b0, root_reg, 2'b01};
    assign sq_ge    = sq_r2 >= sq_trial;
    assign sq_diff  = sq_r2 - sq_trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qx_reg           <= '0;
            qy_reg           <= '0;
            loop_started_reg <= 1'b0;
            loop_par_reg     <= 1'b0;
            region_par_reg   <= 1'b0;
            best_reg         <= '1;
            op_reg           <= ppd_pkg::OP_NOP;
        end
        else
        begin
            op_reg <= cmd.mul_op;
            if (cfg_valid && cfg_index == ppd_pkg::REG_QUERY_X)
            begin
                qx_reg <= cfg_data;
            end
            if (cfg_valid && cfg_index == ppd_pkg::REG_QUERY_Y)
            begin
                qy_reg <= cfg_data;
            end
            if (cmd.accept && !loop_started_reg)
            begin
                loop_started_reg <= 1'b1;
            end
            if (cmd.commit)
            begin
                if (d2 < best_reg)
                begin
                    best_reg <= d2;
                end
                if (crosses)
                begin
                    loop_par_reg <= ~loop_par_reg;
                end
            end
            if (cmd.finish && (end_loop_reg || end_region_reg))
            begin
                region_par_reg   <= region_par_reg ^ loop_par_reg;
                loop_par_reg     <= 1'b0;
                loop_started_reg <= 1'b0;
            end
            if (cmd.out_load)
            begin
                region_par_reg <= 1'b0;
                best_reg       <= '1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            cur_x_reg      <= in_x;
            cur_y_reg      <= in_y;
            end_loop_reg   <= in_last_loop;
            end_region_reg <= in_last_region;
            if (!loop_started_reg)
            begin
                first_x_reg <= in_x;
                first_y_reg <= in_y;
            end
        end
        if (cmd.finish)
        begin
            prev_x_reg <= cur_x_reg;
            prev_y_reg <= cur_y_reg;
        end
        if (cmd.load_edge)
        begin
            px_reg <= qx_reg;
            py_reg <= qy_reg;
            if (cmd.edge_close)
            begin
                ax_reg <= cur_x_reg;
                ay_reg <= cur_y_reg;
                bx_reg <= first_x_reg;
                by_reg <= first_y_reg;
            end
            else
            begin
                ax_reg <= prev_x_reg;
                ay_reg <= prev_y_reg;
                bx_reg <= cur_x_reg;
                by_reg <= cur_y_reg;
            end
        end

        prod_reg <= op_a * op_b;
        case (op_reg)
            ppd_pkg::OP_WXEY: cr_reg  <= TW'(prod_reg);
            ppd_pkg::OP_WYEX: cr_reg  <= cr_reg - TW'(prod_reg);
            ppd_pkg::OP_LHS:  lhs_reg <= prod_reg;
            ppd_pkg::OP_RHS:  rhs_reg <= prod_reg;
            ppd_pkg::OP_EXX:  len_reg <= prod_reg[SW-1:0];
            ppd_pkg::OP_EYY:  len_reg <= len_reg + prod_reg[SW-1:0];
            ppd_pkg::OP_WXE:  dot_reg <= TW'(prod_reg);
            ppd_pkg::OP_WYE:  dot_reg <= dot_reg + TW'(prod_reg);
            ppd_pkg::OP_WXX:  ww_reg  <= prod_reg[SW-1:0];
            ppd_pkg::OP_WYY:  ww_reg  <= ww_reg + prod_reg[SW-1:0];
            ppd_pkg::OP_UXX:  uu_reg  <= prod_reg[SW-1:0];
            ppd_pkg::OP_UYY:  uu_reg  <= uu_reg + prod_reg[SW-1:0];
            ppd_pkg::OP_CLL:  sq_reg  <= {{SW{1'b0}}, prod_reg[SW-1:0]};
            ppd_pkg::OP_CHL:  sq_reg  <= sq_reg + ({{SW{1'b0}}, prod_reg[SW-1:0]} << (N + 2));
            ppd_pkg::OP_CHH:  sq_reg  <= sq_reg + {prod_reg[SW-1:0], {SW{1'b0}}};
            default:          sq_reg  <= sq_reg;
        endcase

        // restoring division of the squared cross product by the edge length
        if (cmd.div_init)
        begin
            dr_reg <= sq_reg[QW+SW-1:QW];
            dl_reg <= sq_reg[QW-1:0];
            q_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            dr_reg <= div_ge ? div_diff[SW-1:0] : div_r2[SW-1:0];
            dl_reg <= {dl_reg[QW-2:0], 1'b0};
            q_reg  <= {q_reg[QW-2:0], div_ge};
        end

        // two bits of the radicand per step
        if (cmd.sqrt_init)
        begin
            ss_reg   <= best_reg;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (cmd.sqrt_step)
        begin
            ss_reg   <= {ss_reg[SW-3:0], 2'b00};
            rem_reg  <= sq_ge ? sq_diff[RW-1:0] : sq_r2[RW-1:0];
            root_reg <= {root_reg[N-1:0], sq_ge};
        end

        if (cmd.out_load)
        begin
            inside_reg <= region_par_reg;
            dist_reg   <= region_par_reg ? '0 : root_reg;
        end
    end

    assign status.loop_started = loop_started_reg;
    assign status.end_loop     = end_loop_reg;
    assign status.end_region   = end_region_reg;
    assign status.need_div     = need_div;
    assign inside_res          = inside_reg;
    assign distance            = dist_reg;

endmodule

// ===== hw/rtl/point_polygon_distance_core.sv =====
// top level of the point to polygon distance core
// Vertices are taken one request at a time. An item opens with an accept; each edge it
// closes (the edge from the previous vertex, and at a loop's end the closing edge) then takes
// a load, the multiply schedule on the single shared multiplier, a check and an update, plus
// the steps of the one-bit-a-cycle restoring divider when the nearest point lies inside the
// segment; a final step then retires the item. The last vertex of a region adds the square
// root steps and a load of the result register; the next vertex is taken while that result
// waits.
module point_polygon_distance_core #(
    parameter int COORD_BITS = 24
) (
    input  logic           clk,
    input  logic           rst_n,
    ppd_cfg_if.sink        cfg,
    ppd_vtx_if.sink        vtx,
    ppd_res_if.source      res
);

    ppd_pkg::ppd_cmd_t    cmd;
    ppd_pkg::ppd_status_t status;

    assign cfg.ready = 1'b1;

    ppd_ctrl #(
        .COORD_BITS (COORD_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vtx.valid),
        .in_ready  (vtx.ready),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .status    (status),
        .cmd       (cmd)
    );

    ppd_datapath #(
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg.valid),
        .cfg_index      (cfg.index),
        .cfg_data       (cfg.data),
        .in_x           (vtx.vertex_x),
        .in_y           (vtx.vertex_y),
        .in_last_loop   (vtx.last_of_loop),
        .in_last_region (vtx.last_of_region),
        .cmd            (cmd),
        .status         (status),
        .inside_res     (res.inside_res),
        .distance       (res.distance)
    );

    a_inside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.inside_res |-> res.distance == '0)
        else $error("inside result with nonzero distance");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        vtx.valid && vtx.ready |=> !vtx.ready)
        else $error("vertex request taken while previous one in work");

    a_div_needed: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> status.need_div)
        else $error("divider running on an edge that needs no division");

    a_mul_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> cmd.mul_op == ppd_pkg::OP_NOP)
        else $error("multiplier active during division");

endmodule
